// ===== rtl/core/fpau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_pkg: shared definitions for the fixed-point arithmetic unit
// Word format, operation codes and the command struct for the serial units.
// ----------------------------------------------------------------------------
package fpau_pkg;

  localparam int INT_BITS  = 32;
  localparam int FRAC_BITS = 32;
  localparam int W         = INT_BITS + FRAC_BITS;
  localparam int DATA_W    = 64;
  localparam int OP_W      = 4;
  localparam int SH_W      = $clog2(W);
  localparam int MUL_CNT_W = $clog2(W);
  localparam int DIV_N     = W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_AND = 4'd4;
  localparam logic [OP_W-1:0] OP_OR  = 4'd5;
  localparam logic [OP_W-1:0] OP_XOR = 4'd6;
  localparam logic [OP_W-1:0] OP_NOT = 4'd7;
  localparam logic [OP_W-1:0] OP_NEG = 4'd8;
  localparam logic [OP_W-1:0] OP_SHL = 4'd9;
  localparam logic [OP_W-1:0] OP_SHR = 4'd10;
  localparam logic [OP_W-1:0] OP_CMP = 4'd11;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    logic start;
    logic ack;
  } unit_cmd_t;

endpackage

// ===== rtl/core/fixed_point_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_arith_unit: signed Q32.32 fixed-point ALU
// Usage: a request beat on the in_ channel carries an op code and two raw
// operands; exactly one result beat with a raw value and three flags follows
// on the out_ channel, in request order.
// Add, sub, logic ops, not, neg, shifts, compare and divide by zero complete
// in the accept cycle: the result is registered and valid in the next cycle.
// Multiply runs a bit-serial shift-add unit: set-up, a shift-add step per
// multiplier bit, then sign fix.
// Divide runs a restoring divider over W + FRAC_BITS dividend bits, one bit
// a cycle, then a sign restore.
// One request is in flight at a time; in_stall is high while a multiply or
// divide runs and while a result is held under out_stall. The output
// register lets a new request in during the cycle a result is taken.
// Reset (rst_n low, synchronous) empties the unit and drops any request in
// progress. While out_stall is high the result beat holds unchanged.
// ----------------------------------------------------------------------------
module fixed_point_arith_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fpau_pkg::OP_W-1:0]          in_req_type,
  input  logic signed [fpau_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [fpau_pkg::DATA_W-1:0] in_operand_b,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fpau_pkg::DATA_W-1:0] out_result_value,
  output logic                               out_div_by_zero,
  output logic                               out_is_equal,
  output logic                               out_is_less
);

  localparam int W = fpau_pkg::W;

  fpau_pkg::word_t                a_w, b_w;
  logic [fpau_pkg::INT_BITS-1:0]  amt;
  logic [fpau_pkg::SH_W-1:0]      sh;
  logic                           sh_ok;
  fpau_pkg::word_t                simple_res;
  logic                           simple_dz, simple_eq, simple_lt;
  logic                           is_mul, is_div, is_long;
  logic                           accept, out_free, unit_done, take;
  fpau_pkg::word_t                mul_res, div_res, unit_res;
  logic                           mul_done, div_done;
  fpau_pkg::unit_cmd_t            mul_cmd, div_cmd;

  logic                           busy_r, busy_nxt;
  logic                           sel_div_r, sel_div_nxt;
  logic                           out_valid_r, out_valid_nxt;
  fpau_pkg::word_t                res_r, res_nxt;
  logic                           dz_r, dz_nxt;
  logic                           eq_r, eq_nxt;
  logic                           lt_r, lt_nxt;

  assign a_w   = in_operand_a[W-1:0];
  assign b_w   = in_operand_b[W-1:0];
  assign amt   = b_w[W-1:fpau_pkg::FRAC_BITS];
  assign sh    = amt[fpau_pkg::SH_W-1:0];
  assign sh_ok = !amt[fpau_pkg::INT_BITS-1] && (amt < fpau_pkg::INT_BITS'(W));

  always_comb begin
    simple_res = '0;
    simple_dz  = 1'b0;
    simple_eq  = 1'b0;
    simple_lt  = 1'b0;
    case (in_req_type)
      fpau_pkg::OP_ADD: simple_res = a_w + b_w;
      fpau_pkg::OP_SUB: simple_res = a_w - b_w;
      fpau_pkg::OP_DIV: simple_dz  = (b_w == '0);
      fpau_pkg::OP_AND: simple_res = a_w & b_w;
      fpau_pkg::OP_OR:  simple_res = a_w | b_w;
      fpau_pkg::OP_XOR: simple_res = a_w ^ b_w;
      fpau_pkg::OP_NOT: simple_res = ~a_w;
      fpau_pkg::OP_NEG: simple_res = '0 - a_w;
      fpau_pkg::OP_SHL: simple_res = sh_ok ? (a_w << sh) : '0;
      fpau_pkg::OP_SHR: begin
        simple_res = sh_ok ? W'($signed(a_w) >>> sh) : {W{a_w[W-1]}};
      end
      fpau_pkg::OP_CMP: begin
        simple_eq = (a_w == b_w);
        simple_lt = ($signed(a_w) < $signed(b_w));
      end
      default: ;
    endcase
  end

  assign is_mul  = (in_req_type == fpau_pkg::OP_MUL);
  assign is_div  = (in_req_type == fpau_pkg::OP_DIV) && (b_w != '0);
  assign is_long = is_mul || is_div;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = busy_r || !out_free;
  assign accept    = in_valid && !in_stall;
  assign unit_done = sel_div_r ? div_done : mul_done;
  assign unit_res  = sel_div_r ? div_res : mul_res;
  assign take      = busy_r && unit_done && out_free;

  assign mul_cmd.start = accept && is_mul;
  assign mul_cmd.ack   = take && !sel_div_r;
  assign div_cmd.start = accept && is_div;
  assign div_cmd.ack   = take && sel_div_r;

  fpau_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mul_cmd),
    .a     (a_w),
    .b     (b_w),
    .done  (mul_done),
    .res   (mul_res)
  );

  fpau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .a     (a_w),
    .b     (b_w),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    busy_nxt      = busy_r;
    sel_div_nxt   = sel_div_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    dz_nxt        = dz_r;
    eq_nxt        = eq_r;
    lt_nxt        = lt_r;
    if (accept) begin
      if (is_long) begin
        busy_nxt    = 1'b1;
        sel_div_nxt = is_div;
      end else begin
        out_valid_nxt = 1'b1;
        res_nxt       = simple_res;
        dz_nxt        = simple_dz;
        eq_nxt        = simple_eq;
        lt_nxt        = simple_lt;
      end
    end else if (take) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      res_nxt       = unit_res;
      dz_nxt        = 1'b0;
      eq_nxt        = 1'b0;
      lt_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sel_div_r <= sel_div_nxt;
    res_r     <= res_nxt;
    dz_r      <= dz_nxt;
    eq_r      <= eq_nxt;
    lt_r      <= lt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = fpau_pkg::DATA_W'($signed(res_r));
  assign out_div_by_zero  = dz_r;
  assign out_is_equal     = eq_r;
  assign out_is_less      = lt_r;

  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r || out_valid_r)
    else $error("accepted beat neither in flight nor presented");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> in_stall)
    else $error("input open while a serial op runs");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dz_r) |-> (res_r == '0 && !eq_r && !lt_r))
    else $error("divide by zero beat carries a value");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(eq_r && lt_r))
    else $error("equal and less both set");

endmodule

// ===== rtl/core/fpau_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_mul: bit-serial signed fixed-point multiplier
// Shift-add over the magnitudes, one multiplier bit per cycle, then a sign
// fix and selection of the scaled product window.
// ----------------------------------------------------------------------------
module fpau_mul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fpau_pkg::unit_cmd_t     cmd,
  input  fpau_pkg::word_t         a,
  input  fpau_pkg::word_t         b,
  output logic                    done,
  output fpau_pkg::word_t         res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int W  = fpau_pkg::W;
  localparam int PW = W + fpau_pkg::FRAC_BITS;

  logic [1:0]                     state_r, state_nxt;
  logic [fpau_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  fpau_pkg::word_t                mcand_r, mcand_nxt;
  fpau_pkg::word_t                p_r, p_nxt;
  fpau_pkg::word_t                q_r, q_nxt;
  logic                           neg_r, neg_nxt;
  fpau_pkg::word_t                res_r, res_nxt;

  logic [W:0]                     sum;
  logic [PW-1:0]                  prod_low;
  logic [PW-1:0]                  prod_sel;
  fpau_pkg::word_t                mag_a, mag_b;

  assign mag_a    = a[W-1] ? (~a + W'(1)) : a;
  assign mag_b    = b[W-1] ? (~b + W'(1)) : b;
  assign sum      = {1'b0, p_r} + (q_r[0] ? {1'b0, mcand_r} : '0);
  assign prod_low = {p_r[fpau_pkg::FRAC_BITS-1:0], q_r};
  assign prod_sel = neg_r ? (~prod_low + PW'(1)) : prod_low;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          mcand_nxt = mag_a;
          q_nxt     = mag_b;
          p_nxt     = '0;
          neg_nxt   = a[W-1] ^ b[W-1];
          cnt_nxt   = fpau_pkg::MUL_CNT_W'(W - 1);
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        p_nxt = sum[W:1];
        q_nxt = {sum[0], q_r[W-1:1]};
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIX: begin
        res_nxt   = prod_sel[PW-1:fpau_pkg::FRAC_BITS];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r   <= cnt_nxt;
    mcand_r <= mcand_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
  end

  assign done = (state_r == S_DONE);
  assign res  = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == S_IDLE)
    else $error("mul started while busy");
  a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ack |-> state_r == S_DONE)
    else $error("mul acknowledged without result");
  a_run_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && cnt_r == '0) |=> state_r == S_FIX)
    else $error("mul did not finish after last bit");

endmodule

// ===== rtl/core/fpau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpau_div: bit-serial signed fixed-point divider
// Restoring division of the scaled dividend magnitude, one quotient bit per
// cycle, then sign restore. Quotient bits above the word wrap away.
// ----------------------------------------------------------------------------
module fpau_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fpau_pkg::unit_cmd_t     cmd,
  input  fpau_pkg::word_t         a,
  input  fpau_pkg::word_t         b,
  output logic                    done,
  output fpau_pkg::word_t         res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int W = fpau_pkg::W;

  logic [1:0]                     state_r, state_nxt;
  logic [fpau_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  fpau_pkg::word_t                n_r, n_nxt;
  fpau_pkg::word_t                mb_r, mb_nxt;
  fpau_pkg::word_t                r_r, r_nxt;
  fpau_pkg::word_t                q_r, q_nxt;
  logic                           neg_r, neg_nxt;
  fpau_pkg::word_t                res_r, res_nxt;

  logic [W:0]                     r2;
  logic [W+1:0]                   diff;
  logic                           borrow;
  fpau_pkg::word_t                mag_a, mag_b;

  assign mag_a  = a[W-1] ? (~a + W'(1)) : a;
  assign mag_b  = b[W-1] ? (~b + W'(1)) : b;
  assign r2     = {r_r, n_r[W-1]};
  assign diff   = {1'b0, r2} - {2'b00, mb_r};
  assign borrow = diff[W+1];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    mb_nxt    = mb_r;
    r_nxt     = r_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          n_nxt     = mag_a;
          mb_nxt    = mag_b;
          r_nxt     = '0;
          q_nxt     = '0;
          neg_nxt   = a[W-1] ^ b[W-1];
          cnt_nxt   = fpau_pkg::DIV_CNT_W'(fpau_pkg::DIV_N - 1);
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        n_nxt = {n_r[W-2:0], 1'b0};
        r_nxt = borrow ? r2[W-1:0] : diff[W-1:0];
        q_nxt = {q_r[W-2:0], ~borrow};
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIX: begin
        res_nxt   = neg_r ? (~q_r + W'(1)) : q_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    n_r   <= n_nxt;
    mb_r  <= mb_nxt;
    r_r   <= r_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done = (state_r == S_DONE);
  assign res  = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == S_IDLE)
    else $error("div started while busy");
  a_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> mb_r != '0)
    else $error("div running with zero divisor");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> r_r < mb_r)
    else $error("partial remainder not below divisor");

endmodule
